// File: sv/eaa_pkg.sv
// ----------------------------------------------------------------------------
// eaa_pkg
// Shared types and constants for the environment alarm annunciator: register
// indexes, reset values, burst windows and the result payload.
// ----------------------------------------------------------------------------
package eaa_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 9;

   // Configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      REG_TEMP_HIGH    = 3'd0,
      REG_TEMP_LOW     = 3'd1,
      REG_HUMID_HIGH   = 3'd2,
      REG_HUMID_LOW    = 3'd3,
      REG_PERSIST      = 3'd4,
      REG_PATTERN      = 3'd5,
      REG_POLL         = 3'd6,
      REG_RUN          = 3'd7
   } reg_index_type;

   // Register reset values
   localparam logic [7:0] TempHighReset  = 8'd30;
   localparam logic [7:0] TempLowReset   = 8'd20;
   localparam logic [7:0] HumidHighReset = 8'd70;
   localparam logic [7:0] HumidLowReset  = 8'd10;
   localparam logic [8:0] PersistReset   = 9'd500;
   localparam logic [8:0] PatternReset   = 9'd300;
   localparam logic [7:0] PollReset      = 8'd200;
   localparam logic [6:0] RunReset       = 7'd100;

   // Burst windows inside one pattern cycle (inclusive bounds)
   localparam logic [8:0] Burst0End   = 9'd10;
   localparam logic [8:0] Burst1Start = 9'd30;
   localparam logic [8:0] Burst1End   = 9'd40;
   localparam logic [8:0] Burst2Start = 9'd60;
   localparam logic [8:0] Burst2End   = 9'd70;
   localparam logic [8:0] Burst3Start = 9'd90;
   localparam logic [8:0] Burst3End   = 9'd100;

   typedef struct packed {
      logic [7:0] temp_high_limit;
      logic [7:0] temp_low_limit;
      logic [7:0] humid_high_limit;
      logic [7:0] humid_low_limit;
      logic [8:0] persist_ticks;
      logic [8:0] pattern_period;
      logic [7:0] poll_period;
      logic [6:0] run_period;
   } cfg_type;

   typedef struct packed {
      logic       read_request;
      logic       beeper_on;
      logic       alarm_lamp;
      logic       limit_lamp;
      logic       over_limit;
      logic [6:0] run_phase;
   } rsp_type;

   // Three-burst pattern used by the limit lamp
   function automatic logic limit_burst(input logic [8:0] c);
      limit_burst = (c <= Burst0End) ||
                    (c >= Burst1Start && c <= Burst1End) ||
                    (c >= Burst2Start && c <= Burst2End);
   endfunction

   // Four-burst pattern used by the clock alarm
   function automatic logic alarm_burst(input logic [8:0] c);
      alarm_burst = limit_burst(c) || (c >= Burst3Start && c <= Burst3End);
   endfunction

endpackage

// File: sv/eaa_channels.sv
// ----------------------------------------------------------------------------
// eaa channels
// Valid/ready channel interfaces for tick beats in and result beats out.
// ----------------------------------------------------------------------------
interface eaa_req_if;
   logic       valid;
   logic       ready;
   logic       alarm_active;
   logic [7:0] temp_reading;
   logic [7:0] humid_reading;

   modport source (output valid, alarm_active, temp_reading, humid_reading, input ready);
   modport sink   (input valid, alarm_active, temp_reading, humid_reading, output ready);
endinterface

interface eaa_rsp_if;
   logic       valid;
   logic       ready;
   logic       read_request;
   logic       beeper_on;
   logic       alarm_lamp;
   logic       limit_lamp;
   logic       over_limit;
   logic [6:0] run_phase;

   modport source (output valid, read_request, beeper_on, alarm_lamp, limit_lamp,
                   over_limit, run_phase, input ready);
   modport sink   (input valid, read_request, beeper_on, alarm_lamp, limit_lamp,
                   over_limit, run_phase, output ready);
endinterface

// File: sv/eaa_csr.sv
// ----------------------------------------------------------------------------
// eaa_csr
// Configuration register file: eight limit and period registers, write only.
// ----------------------------------------------------------------------------
module eaa_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [eaa_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [eaa_pkg::CsrDataWidth-1:0]     csr_wdata,
   output eaa_pkg::cfg_type                     cfg
);

   eaa_pkg::cfg_type cfg_ff, cfg_in;

   // Select the register addressed by the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (eaa_pkg::reg_index_type'(csr_index))
            eaa_pkg::REG_TEMP_HIGH:  cfg_in.temp_high_limit  = csr_wdata[7:0];
            eaa_pkg::REG_TEMP_LOW:   cfg_in.temp_low_limit   = csr_wdata[7:0];
            eaa_pkg::REG_HUMID_HIGH: cfg_in.humid_high_limit = csr_wdata[7:0];
            eaa_pkg::REG_HUMID_LOW:  cfg_in.humid_low_limit  = csr_wdata[7:0];
            eaa_pkg::REG_PERSIST:    cfg_in.persist_ticks    = csr_wdata[8:0];
            eaa_pkg::REG_PATTERN:    cfg_in.pattern_period   = csr_wdata[8:0];
            eaa_pkg::REG_POLL:       cfg_in.poll_period      = csr_wdata[7:0];
            eaa_pkg::REG_RUN:        cfg_in.run_period       = csr_wdata[6:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Load reset values, then hold until written
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_high_limit  <= eaa_pkg::TempHighReset;
         cfg_ff.temp_low_limit   <= eaa_pkg::TempLowReset;
         cfg_ff.humid_high_limit <= eaa_pkg::HumidHighReset;
         cfg_ff.humid_low_limit  <= eaa_pkg::HumidLowReset;
         cfg_ff.persist_ticks    <= eaa_pkg::PersistReset;
         cfg_ff.pattern_period   <= eaa_pkg::PatternReset;
         cfg_ff.poll_period      <= eaa_pkg::PollReset;
         cfg_ff.run_period       <= eaa_pkg::RunReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/eaa_core.sv
// ----------------------------------------------------------------------------
// eaa_core
// Per-tick counter state and result logic; state advances on each accepted
// tick beat and the result for that tick is produced in the same cycle.
// ----------------------------------------------------------------------------
module eaa_core (
   input  logic              clock,
   input  logic              reset,
   input  eaa_pkg::cfg_type  cfg,
   input  logic              tick_take,
   input  logic              alarm_active,
   input  logic [7:0]        temp_reading,
   input  logic [7:0]        humid_reading,
   output eaa_pkg::rsp_type  result
);

   logic [7:0] poll_count_ff,    poll_count_in;
   logic [8:0] alarm_count_ff,   alarm_count_in;
   logic [6:0] run_count_ff,     run_count_in;
   logic [8:0] persist_count_ff, persist_count_in;
   logic [8:0] limit_count_ff,   limit_count_in;
   logic       limit_flag_ff,    limit_flag_in;
   logic       beeper_state_ff,  beeper_state_in;

   logic [8:0]  poll_sum;
   logic [9:0]  alarm_sum;
   logic [7:0]  run_sum;
   logic [9:0]  persist_sum;
   logic [9:0]  limit_sum;
   logic        poll_wrap, alarm_wrap, run_wrap, persist_wrap, limit_wrap;
   logic        out_of_limit;
   logic        alarm_lamp, limit_lamp;

   // Increment each counter and check it against its period
   always_comb begin
      poll_sum    = {1'b0, poll_count_ff} + 9'd1;
      alarm_sum   = {1'b0, alarm_count_ff} + 10'd1;
      run_sum     = {1'b0, run_count_ff} + 8'd1;
      persist_sum = {1'b0, persist_count_ff} + 10'd1;
      limit_sum   = {1'b0, limit_count_ff} + 10'd1;

      poll_wrap    = poll_sum[8] || (poll_sum >= {1'b0, cfg.poll_period});
      alarm_wrap   = alarm_sum[9] || (alarm_sum >= {1'b0, cfg.pattern_period});
      run_wrap     = run_sum[7] || (run_sum >= {1'b0, cfg.run_period});
      persist_wrap = persist_sum[9] || (persist_sum >= {1'b0, cfg.persist_ticks});
      limit_wrap   = limit_sum[9] || (limit_sum >= {1'b0, cfg.pattern_period});
   end

   // Compare readings against the limits
   assign out_of_limit = (temp_reading >= cfg.temp_high_limit) ||
                         (temp_reading <= cfg.temp_low_limit) ||
                         (humid_reading >= cfg.humid_high_limit) ||
                         (humid_reading <= cfg.humid_low_limit);

   // Next state and lamp outputs for this tick
   always_comb begin
      poll_count_in = poll_wrap ? 8'd0 : poll_sum[7:0];
      run_count_in  = run_wrap ? 7'd0 : run_sum[6:0];

      // Clock alarm pattern drives the beeper directly
      beeper_state_in = beeper_state_ff;
      if (alarm_active) begin
         alarm_count_in  = alarm_wrap ? 9'd0 : alarm_sum[8:0];
         alarm_lamp      = eaa_pkg::alarm_burst(alarm_count_in);
         beeper_state_in = alarm_lamp;
      end else begin
         alarm_count_in = 9'd0;
         alarm_lamp     = 1'b0;
      end

      // Persistence: set the flag when the count wraps, clear on any good tick
      if (out_of_limit) begin
         persist_count_in = persist_wrap ? 9'd0 : persist_sum[8:0];
         limit_flag_in    = limit_flag_ff || persist_wrap;
      end else begin
         persist_count_in = 9'd0;
         limit_flag_in    = 1'b0;
      end

      if (limit_flag_in) begin
         limit_count_in = limit_wrap ? 9'd0 : limit_sum[8:0];
         limit_lamp     = eaa_pkg::limit_burst(limit_count_in);
      end else begin
         limit_count_in = 9'd0;
         limit_lamp     = 1'b0;
      end

      // Drop the beeper when neither alarm is active
      if (!alarm_active && !limit_flag_in) begin
         beeper_state_in = 1'b0;
      end
   end

   // Advance state on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_count_ff    <= '0;
         alarm_count_ff   <= '0;
         run_count_ff     <= '0;
         persist_count_ff <= '0;
         limit_count_ff   <= '0;
         limit_flag_ff    <= 1'b0;
         beeper_state_ff  <= 1'b0;
      end else if (tick_take) begin
         poll_count_ff    <= poll_count_in;
         alarm_count_ff   <= alarm_count_in;
         run_count_ff     <= run_count_in;
         persist_count_ff <= persist_count_in;
         limit_count_ff   <= limit_count_in;
         limit_flag_ff    <= limit_flag_in;
         beeper_state_ff  <= beeper_state_in;
      end
   end

   always_comb begin
      result.read_request = poll_wrap;
      result.beeper_on    = beeper_state_in;
      result.alarm_lamp   = alarm_lamp;
      result.limit_lamp   = limit_lamp;
      result.over_limit   = limit_flag_in;
      result.run_phase    = run_count_in;
   end

endmodule

// File: sv/eaa_outbuf.sv
// ----------------------------------------------------------------------------
// eaa_outbuf
// Two-entry result register with skid slot, so a new tick can be taken while
// a finished result still waits for the receiver.
// ----------------------------------------------------------------------------
module eaa_outbuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  eaa_pkg::rsp_type  push_data,
   output logic              can_push,
   output logic              head_valid,
   input  logic              pop,
   output eaa_pkg::rsp_type  head_data
);

   eaa_pkg::rsp_type head_ff, head_in;
   eaa_pkg::rsp_type skid_ff, skid_in;
   logic             head_vld_ff, head_vld_in;
   logic             skid_vld_ff, skid_vld_in;

   // Steer pushed beats into the head or the skid slot
   always_comb begin
      head_in     = head_ff;
      skid_in     = skid_ff;
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            head_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (head_vld_ff) begin
         if (push && pop) begin
            head_in = push_data;
         end else if (push) begin
            skid_in     = push_data;
            skid_vld_in = 1'b1;
         end else if (pop) begin
            head_vld_in = 1'b0;
         end
      end else if (push) begin
         head_in     = push_data;
         head_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign can_push   = !skid_vld_ff;
   assign head_valid = head_vld_ff;
   assign head_data  = head_ff;

endmodule

// File: sv/environment_alarm_annunciator.sv
// ----------------------------------------------------------------------------
// environment_alarm_annunciator
// Tick-driven annunciator: sensor poll pulse, clock alarm beeper/lamp bursts,
// over-limit detection with a blinking limit lamp, and a run phase counter.
//
// Usage:
//   req_chan carries one beat per 10 ms tick (alarm request, temperature,
//   humidity); rsp_chan returns exactly one result beat per tick, in order.
//   csr_we/csr_index/csr_wdata write the eight limit and period registers;
//   write them only while no tick is in flight.
//   A result enters the head register, or the skid slot if the head is full,
//   when its tick beat is accepted. Throughput: one tick per cycle while the
//   result buffer has room; all counter updates are a single add and compare
//   per counter, finished between the input port and the result register.
//   A two-entry result buffer keeps req_chan.ready high while one result
//   waits; with both entries full and the receiver stalled, req_chan.ready
//   drops until a result beat is taken.
//   Reset clears all counters, the over-limit flag, the beeper and the result
//   buffer, and loads the register defaults.
// ----------------------------------------------------------------------------
module environment_alarm_annunciator (
   input  logic                               clock,
   input  logic                               reset,
   eaa_req_if.sink                            req_chan,
   eaa_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [eaa_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [eaa_pkg::CsrDataWidth-1:0]   csr_wdata
);

   eaa_pkg::cfg_type cfg;
   eaa_pkg::rsp_type tick_result;
   eaa_pkg::rsp_type head_data;
   logic             can_push;
   logic             tick_take;

   // Accept a tick beat whenever the result buffer has room
   assign req_chan.ready = can_push;
   assign tick_take      = req_chan.valid && can_push;

   eaa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   eaa_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .tick_take     (tick_take),
      .alarm_active  (req_chan.alarm_active),
      .temp_reading  (req_chan.temp_reading),
      .humid_reading (req_chan.humid_reading),
      .result        (tick_result)
   );

   eaa_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .push       (tick_take),
      .push_data  (tick_result),
      .can_push   (can_push),
      .head_valid (rsp_chan.valid),
      .pop        (rsp_chan.valid && rsp_chan.ready),
      .head_data  (head_data)
   );

   // Drive result beat fields
   assign rsp_chan.read_request = head_data.read_request;
   assign rsp_chan.beeper_on    = head_data.beeper_on;
   assign rsp_chan.alarm_lamp   = head_data.alarm_lamp;
   assign rsp_chan.limit_lamp   = head_data.limit_lamp;
   assign rsp_chan.over_limit   = head_data.over_limit;
   assign rsp_chan.run_phase    = head_data.run_phase;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// environment_alarm_annunciator testbench
// Drives tick beats through a queue-fed driver, predicts each result beat
// with a cycle model of the annunciator counters, and compares every result
// field with the oldest prediction. Runs a short directed set, then random
// alarm and limit episodes under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned BurstPitch  = 30;
   localparam int unsigned BurstLength = 10;
   localparam int unsigned AlarmBursts = 4;
   localparam int unsigned LimitBursts = 3;
   localparam int unsigned IdlePercent = 10;

   typedef struct packed {
      logic       alarm_active;
      logic [7:0] temp_reading;
      logic [7:0] humid_reading;
   } tick_type;

   logic clock;
   logic reset;
   logic                              csr_we;
   logic [eaa_pkg::CsrIndexWidth-1:0] csr_index;
   logic [eaa_pkg::CsrDataWidth-1:0]  csr_wdata;

   eaa_req_if req_chan ();
   eaa_rsp_if rsp_chan ();

   environment_alarm_annunciator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted register settings and counter state
   eaa_pkg::cfg_type limits = '{eaa_pkg::TempHighReset, eaa_pkg::TempLowReset,
                                eaa_pkg::HumidHighReset, eaa_pkg::HumidLowReset,
                                eaa_pkg::PersistReset, eaa_pkg::PatternReset,
                                eaa_pkg::PollReset, eaa_pkg::RunReset};
   logic [7:0] poll_count    = '0;
   logic [8:0] alarm_count   = '0;
   logic [6:0] run_count     = '0;
   logic [8:0] persist_count = '0;
   logic [8:0] limit_count   = '0;
   bit         limit_flag    = 1'b0;
   bit         beeper_state  = 1'b0;

   tick_type          pending_ticks[$];
   eaa_pkg::rsp_type  expected_outputs[$];
   bit       tick_taken = 1'b0;
   bit       calm       = 1'b0;
   int       failures   = 0;

   // Advance a counter, wrapping at its period or past its width
   function automatic logic [8:0] step_count(input logic [8:0] count,
                                             input int unsigned period,
                                             input int unsigned mask,
                                             output bit wrapped);
      int unsigned bumped;
      bumped  = 32'(count) + 1;
      wrapped = (bumped >= period) || (bumped > mask);
      return wrapped ? 9'd0 : bumped[8:0];
   endfunction

   // Lit when the count falls in one of the first few bursts of a cycle
   function automatic bit in_burst(input logic [8:0] count, input int unsigned bursts);
      for (int unsigned k = 0; k < bursts; k++)
         if (count >= BurstPitch * k && count <= BurstPitch * k + BurstLength)
            return 1'b1;
      return 1'b0;
   endfunction

   // Advance all counters by one tick and form the result beat
   function automatic eaa_pkg::rsp_type annunciate_tick(input tick_type t);
      eaa_pkg::rsp_type r;
      bit      wrapped;
      bit      out_of_limit;
      r = '0;
      poll_count     = 8'(step_count({1'b0, poll_count}, 32'(limits.poll_period),
                                     'hFF, wrapped));
      r.read_request = wrapped;

      if (t.alarm_active) begin
         alarm_count  = step_count(alarm_count, 32'(limits.pattern_period), 'h1FF, wrapped);
         r.alarm_lamp = in_burst(alarm_count, AlarmBursts);
         beeper_state = r.alarm_lamp;
      end else begin
         alarm_count  = '0;
      end

      run_count = 7'(step_count({2'b0, run_count}, 32'(limits.run_period), 'h7F, wrapped));

      out_of_limit = t.temp_reading >= limits.temp_high_limit ||
                     t.temp_reading <= limits.temp_low_limit ||
                     t.humid_reading >= limits.humid_high_limit ||
                     t.humid_reading <= limits.humid_low_limit;
      if (out_of_limit) begin
         persist_count = step_count(persist_count, 32'(limits.persist_ticks), 'h1FF,
                                    wrapped);
         if (wrapped)
            limit_flag = 1'b1;
      end else begin
         persist_count = '0;
         limit_flag    = 1'b0;
      end

      if (limit_flag) begin
         limit_count  = step_count(limit_count, 32'(limits.pattern_period), 'h1FF, wrapped);
         r.limit_lamp = in_burst(limit_count, LimitBursts);
      end else begin
         limit_count  = '0;
      end

      // Beeper holds its value while only the over-limit flag is up
      if (!t.alarm_active && !limit_flag)
         beeper_state = 1'b0;

      r.beeper_on  = beeper_state;
      r.over_limit = limit_flag;
      r.run_phase  = run_count;
      return r;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endfunction

   // Clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Check result beats, then predict the tick beat taken at this edge
   always @(posedge clock) begin : check_and_predict
      eaa_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_outputs.size() == 0) begin
            $error("result beat with no tick outstanding");
            failures++;
         end else begin
            want = expected_outputs.pop_front();
            check_field("read_request", 32'(want.read_request), 32'(rsp_chan.read_request));
            check_field("beeper_on", 32'(want.beeper_on), 32'(rsp_chan.beeper_on));
            check_field("alarm_lamp", 32'(want.alarm_lamp), 32'(rsp_chan.alarm_lamp));
            check_field("limit_lamp", 32'(want.limit_lamp), 32'(rsp_chan.limit_lamp));
            check_field("over_limit", 32'(want.over_limit), 32'(rsp_chan.over_limit));
            check_field("run_phase", 32'(want.run_phase), 32'(rsp_chan.run_phase));
         end
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_outputs.push_back(annunciate_tick({req_chan.alarm_active,
                                                     req_chan.temp_reading,
                                                     req_chan.humid_reading}));
         tick_taken = 1'b1;
      end
   end

   // Drive the next tick beat once the current one is taken, idling at random
   always @(negedge clock) begin : drive_ticks
      tick_type beat;
      if (!req_chan.valid || tick_taken) begin
         tick_taken = 1'b0;
         if (pending_ticks.size() != 0 &&
             (calm || $urandom_range(99) >= IdlePercent)) begin
            beat = pending_ticks.pop_front();
            req_chan.valid         <= 1'b1;
            req_chan.alarm_active  <= beat.alarm_active;
            req_chan.temp_reading  <= beat.temp_reading;
            req_chan.humid_reading <= beat.humid_reading;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Stall the result side at random
   always @(negedge clock)
      rsp_chan.ready <= calm || $urandom_range(99) >= IdlePercent;

   task automatic write_register(input eaa_pkg::reg_index_type idx, input logic [8:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         eaa_pkg::REG_TEMP_HIGH:  limits.temp_high_limit  = value[7:0];
         eaa_pkg::REG_TEMP_LOW:   limits.temp_low_limit   = value[7:0];
         eaa_pkg::REG_HUMID_HIGH: limits.humid_high_limit = value[7:0];
         eaa_pkg::REG_HUMID_LOW:  limits.humid_low_limit  = value[7:0];
         eaa_pkg::REG_PERSIST:    limits.persist_ticks    = value;
         eaa_pkg::REG_PATTERN:    limits.pattern_period   = value;
         eaa_pkg::REG_POLL:       limits.poll_period      = value[7:0];
         eaa_pkg::REG_RUN:        limits.run_period       = value[6:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input int t_hi, input int t_lo, input int h_hi, input int h_lo,
                            input int persist, input int pattern, input int poll,
                            input int run);
      write_register(eaa_pkg::REG_TEMP_HIGH, 9'(t_hi));
      write_register(eaa_pkg::REG_TEMP_LOW, 9'(t_lo));
      write_register(eaa_pkg::REG_HUMID_HIGH, 9'(h_hi));
      write_register(eaa_pkg::REG_HUMID_LOW, 9'(h_lo));
      write_register(eaa_pkg::REG_PERSIST, 9'(persist));
      write_register(eaa_pkg::REG_PATTERN, 9'(pattern));
      write_register(eaa_pkg::REG_POLL, 9'(poll));
      write_register(eaa_pkg::REG_RUN, 9'(run));
   endtask

   task automatic push_tick(input bit alarm, input int temp, input int humid);
      pending_ticks.push_back('{alarm, temp[7:0], humid[7:0]});
   endtask

   // One run of ticks with a steady alarm and a steady limit condition
   task automatic push_episode(input bit alarm, input bit want_out, input int length);
      int t_hi, t_lo, h_hi, h_lo;
      t_hi = limits.temp_high_limit;
      t_lo = limits.temp_low_limit;
      h_hi = limits.humid_high_limit;
      h_lo = limits.humid_low_limit;
      for (int i = 0; i < length; i++) begin
         int temp, humid;
         temp  = $urandom_range(255);
         humid = $urandom_range(255);
         // Leave a few ticks as noise that may break the run
         if ($urandom_range(99) >= 5) begin
            if (want_out) begin
               case ($urandom_range(3))
                  0: temp  = $urandom_range(255, t_hi);
                  1: temp  = $urandom_range(t_lo, 0);
                  2: humid = $urandom_range(255, h_hi);
                  default: humid = $urandom_range(h_lo, 0);
               endcase
            end else if (t_hi > t_lo + 1 && h_hi > h_lo + 1) begin
               temp  = $urandom_range(t_hi - 1, t_lo + 1);
               humid = $urandom_range(h_hi - 1, h_lo + 1);
            end
         end
         push_tick(alarm, temp, humid);
      end
   endtask

   task automatic push_episodes(input int count, input int max_run);
      int made, length;
      made = 0;
      while (made < count) begin
         length = $urandom_range(max_run, 1);
         if ($urandom_range(99) < 15) begin
            for (int i = 0; i < length; i++)
               push_tick(1'($urandom_range(1)), $urandom_range(255), $urandom_range(255));
         end else begin
            push_episode(1'($urandom_range(1)), $urandom_range(99) < 60, length);
         end
         made += length;
      end
   endtask

   // Wait until every tick is taken and every result has arrived
   task automatic settle();
      while (pending_ticks.size() != 0 || req_chan.valid || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin : stimulus
      int t_lo, h_lo;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = eaa_pkg::REG_TEMP_HIGH;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.alarm_active  = 1'b0;
      req_chan.temp_reading  = '0;
      req_chan.humid_reading = '0;
      rsp_chan.ready         = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes and limit edges at the reset settings
      push_tick(0, 25, 40);
      push_tick(1, 25, 40);
      push_tick(1, 0, 40);
      push_tick(1, 255, 40);
      push_tick(1, 20, 40);
      push_tick(1, 21, 40);
      push_tick(1, 29, 40);
      push_tick(1, 30, 40);
      push_tick(0, 25, 0);
      push_tick(0, 25, 255);
      push_tick(0, 25, 10);
      push_tick(0, 25, 11);
      push_tick(0, 25, 69);
      push_tick(0, 25, 70);
      push_tick(1, 255, 255);
      push_tick(0, 0, 0);
      push_tick(1, 85, 170);
      push_tick(0, 170, 85);
      settle();

      // Shortest periods, widest limits, flag after one tick
      write_all(255, 0, 255, 0, 1, 101, 1, 1);
      push_tick(1, 255, 0);
      push_tick(0, 255, 0);
      push_tick(0, 128, 128);
      push_tick(1, 0, 255);
      push_episodes(30, 20);
      settle();

      // Longest periods, reset limits, short persistence
      write_all(30, 20, 70, 10, 3, 511, 255, 127);
      push_episodes(40, 60);
      settle();

      // Everything out of limit, longest persistence, no idling
      calm = 1'b1;
      write_all(0, 0, 0, 0, 511, 300, 200, 100);
      push_episodes(540, 30);
      settle();
      calm = 1'b0;

      // Random settings, periods lowered below running counters
      repeat (2) begin
         t_lo = $urandom_range(120);
         h_lo = $urandom_range(120);
         write_all($urandom_range(255, t_lo), t_lo, $urandom_range(255, h_lo), h_lo,
                   $urandom_range(40, 1), $urandom_range(511, 101),
                   $urandom_range(255, 1), $urandom_range(127, 1));
         push_episodes(20, 30);
         settle();
      end

      repeat (5) @(posedge clock);
      if (failures == 0 && expected_outputs.size() == 0)
         $display("environment_alarm_annunciator regression: pass");
      else
         $display("environment_alarm_annunciator regression: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("environment_alarm_annunciator regression: fail");
      $finish;
   end

endmodule

// File: sim.f
sv/eaa_pkg.sv
sv/eaa_channels.sv
sv/eaa_csr.sv
sv/eaa_core.sv
sv/eaa_outbuf.sv
sv/environment_alarm_annunciator.sv
test/tb.sv
